// File: rtl/bst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bst_pkg;

  localparam int POS_WIDTH = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] KIND_EOF    = 4'd0;
  localparam logic [3:0] KIND_NL     = 4'd1;
  localparam logic [3:0] KIND_LPAREN = 4'd2;
  localparam logic [3:0] KIND_RPAREN = 4'd3;
  localparam logic [3:0] KIND_LBRACE = 4'd4;
  localparam logic [3:0] KIND_RBRACE = 4'd5;
  localparam logic [3:0] KIND_LESS   = 4'd6;
  localparam logic [3:0] KIND_PLUS   = 4'd7;
  localparam logic [3:0] KIND_MINUS  = 4'd8;
  localparam logic [3:0] KIND_ASSIGN = 4'd9;
  localparam logic [3:0] KIND_IDENT  = 4'd10;
  localparam logic [3:0] KIND_WHILE  = 4'd11;
  localparam logic [3:0] KIND_INT    = 4'd12;
  localparam logic [3:0] KIND_ERROR  = 4'd13;

  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_NO_EQUAL = 2'd1;
  localparam logic [1:0] CAUSE_BAD_CHAR = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [2:0] KW_LEN = 3'd5;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [1:0]  cause;
  } tok_t;

  // one accepted byte's results: one or two tokens
  typedef struct packed {
    logic two;
    tok_t first;
    tok_t second;
  } entry_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == CH_UNDER);
  endfunction

  // characters of "while"
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h77;
      3'd1:    r = 8'h68;
      3'd2:    r = 8'h69;
      3'd3:    r = 8'h6C;
      3'd4:    r = 8'h65;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/bst_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bst_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic              full,
  input  wire logic [7:0]        text_byte,
  output logic                   q_push,
  output bst_pkg::entry_t        q_entry
);

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_CR    = 3'd1;
  localparam logic [2:0] MODE_COLON = 3'd2;
  localparam logic [2:0] MODE_IDENT = 3'd3;
  localparam logic [2:0] MODE_INT   = 3'd4;
  localparam logic [2:0] MODE_ERROR = 3'd5;

  localparam logic [bst_pkg::POS_WIDTH-1:0] POS_TOP = {bst_pkg::POS_WIDTH{1'b1}};

  typedef struct packed {
    logic          emit;
    bst_pkg::tok_t tok;
    logic [2:0]    mode;
    logic          set_pend;
    logic          ident;
    logic          restart;
  } idle_t;

  function automatic idle_t idle_scan(input logic [7:0] c, input logic [15:0] s16);
    idle_t r;
    r = '0;
    r.mode = MODE_IDLE;
    r.tok.start = s16;
    r.tok.kind = bst_pkg::KIND_EOF;
    r.emit = 1'b1;
    unique case (c)
      bst_pkg::CH_SPACE, bst_pkg::CH_TAB: r.emit = 1'b0;
      bst_pkg::CH_NUL: r.restart = 1'b1;
      bst_pkg::CH_CR: begin
        r.emit = 1'b0;
        r.set_pend = 1'b1;
        r.mode = MODE_CR;
      end
      bst_pkg::CH_LF:     r.tok.kind = bst_pkg::KIND_NL;
      bst_pkg::CH_LPAREN: r.tok.kind = bst_pkg::KIND_LPAREN;
      bst_pkg::CH_RPAREN: r.tok.kind = bst_pkg::KIND_RPAREN;
      bst_pkg::CH_LBRACE: r.tok.kind = bst_pkg::KIND_LBRACE;
      bst_pkg::CH_RBRACE: r.tok.kind = bst_pkg::KIND_RBRACE;
      bst_pkg::CH_LESS:   r.tok.kind = bst_pkg::KIND_LESS;
      bst_pkg::CH_PLUS:   r.tok.kind = bst_pkg::KIND_PLUS;
      bst_pkg::CH_MINUS:  r.tok.kind = bst_pkg::KIND_MINUS;
      bst_pkg::CH_COLON: begin
        r.emit = 1'b0;
        r.set_pend = 1'b1;
        r.mode = MODE_COLON;
      end
      default: begin
        if (bst_pkg::is_word_start(c)) begin
          r.emit = 1'b0;
          r.set_pend = 1'b1;
          r.ident = 1'b1;
          r.mode = MODE_IDENT;
        end else if (bst_pkg::is_digit(c)) begin
          r.emit = 1'b0;
          r.set_pend = 1'b1;
          r.mode = MODE_INT;
        end else begin
          r.tok.kind = bst_pkg::KIND_ERROR;
          r.tok.cause = bst_pkg::CAUSE_BAD_CHAR;
          r.mode = MODE_ERROR;
        end
      end
    endcase
    return r;
  endfunction

  logic [2:0]                    mode;
  logic [2:0]                    mode_next;
  logic [bst_pkg::POS_WIDTH-1:0] pos;
  logic [bst_pkg::POS_WIDTH-1:0] pos_next;
  logic [bst_pkg::POS_WIDTH-1:0] pend;
  logic [bst_pkg::POS_WIDTH-1:0] pend_next;
  logic [2:0]                    kw_prog;
  logic [2:0]                    kw_prog_next;
  logic                          kw_poss;
  logic                          kw_poss_next;

  logic          accept;
  logic          use_idle;
  logic          have0;
  logic          restart;
  idle_t         s;
  bst_pkg::tok_t tok_end;

  assign accept = push && !full;
  assign s = idle_scan(text_byte, 16'(pos));

  always_comb begin
    tok_end        = '0;
    tok_end.start  = 16'(pend);
    tok_end.length = 16'(pos - pend);
    tok_end.kind   = (kw_poss && (kw_prog == bst_pkg::KW_LEN)) ?
                     bst_pkg::KIND_WHILE : bst_pkg::KIND_IDENT;

    mode_next    = mode;
    pend_next    = pend;
    kw_prog_next = kw_prog;
    kw_poss_next = kw_poss;
    use_idle     = 1'b0;
    have0        = 1'b0;
    restart      = 1'b0;
    q_entry      = '0;

    unique case (mode)
      MODE_ERROR: ;
      MODE_CR: begin
        q_entry.first = '0;
        q_entry.first.kind = bst_pkg::KIND_NL;
        q_entry.first.start = 16'(pend);
        have0 = 1'b1;
        mode_next = MODE_IDLE;
        use_idle = (text_byte != bst_pkg::CH_LF);
      end
      MODE_COLON: begin
        have0 = 1'b1;
        if (text_byte == bst_pkg::CH_EQUAL) begin
          q_entry.first.kind = bst_pkg::KIND_ASSIGN;
          q_entry.first.start = 16'(pend);
          mode_next = MODE_IDLE;
        end else begin
          q_entry.first.kind = bst_pkg::KIND_ERROR;
          q_entry.first.start = 16'(pos);
          q_entry.first.cause = bst_pkg::CAUSE_NO_EQUAL;
          mode_next = MODE_ERROR;
        end
      end
      MODE_IDENT: begin
        if (bst_pkg::is_word_start(text_byte) || bst_pkg::is_digit(text_byte)) begin
          if (kw_poss && (kw_prog < bst_pkg::KW_LEN) &&
              (text_byte == bst_pkg::kw_char(kw_prog))) begin
            kw_prog_next = kw_prog + 3'd1;
          end else begin
            kw_poss_next = 1'b0;
          end
        end else begin
          q_entry.first = tok_end;
          have0 = 1'b1;
          use_idle = 1'b1;
        end
      end
      MODE_INT: begin
        if (!bst_pkg::is_digit(text_byte)) begin
          q_entry.first = tok_end;
          q_entry.first.kind = bst_pkg::KIND_INT;
          have0 = 1'b1;
          use_idle = 1'b1;
        end
      end
      default: use_idle = 1'b1;
    endcase

    if (use_idle) begin
      mode_next = s.mode;
      restart = s.restart;
      if (s.set_pend) begin
        pend_next = pos;
      end
      if (s.ident) begin
        kw_prog_next = (text_byte == bst_pkg::kw_char(3'd0)) ? 3'd1 : 3'd0;
        kw_poss_next = (text_byte == bst_pkg::kw_char(3'd0));
      end
      if (s.emit || s.restart) begin
        if (have0) begin
          q_entry.second = s.tok;
          q_entry.two = 1'b1;
        end else begin
          q_entry.first = s.tok;
          have0 = 1'b1;
        end
      end
    end

    if (restart) begin
      pos_next = '0;
    end else if (pos != POS_TOP) begin
      pos_next = pos + 1'b1;
    end else begin
      pos_next = pos;
    end
  end

  assign q_push = accept && have0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      pos     <= '0;
      pend    <= '0;
      kw_prog <= 3'd0;
      kw_poss <= 1'b1;
    end else if (accept) begin
      mode    <= mode_next;
      pos     <= pos_next;
      pend    <= pend_next;
      kw_prog <= kw_prog_next;
      kw_poss <= kw_poss_next;
    end
  end

  a_no_push_after_error: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_ERROR) |-> !q_push)
    else $error("transaction produced after error");

  a_kw_prog_range: assert property (@(posedge clk) disable iff (rst)
    kw_prog <= bst_pkg::KW_LEN)
    else $error("keyword progress out of range");

  a_eof_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && restart) |=> (pos == '0) && (mode == MODE_IDLE))
    else $error("end of text did not restart");

endmodule
`default_nettype wire

// File: rtl/bst_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module bst_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr,
  input  wire bst_pkg::entry_t wr_data,
  input  wire logic            rd,
  output bst_pkg::entry_t      rd_data,
  output logic                 full,
  output logic                 empty
);

  bst_pkg::entry_t               slots [bst_pkg::QUEUE_DEPTH];
  logic [bst_pkg::QUEUE_AW-1:0]  wptr;
  logic [bst_pkg::QUEUE_AW-1:0]  rptr;
  logic [bst_pkg::QUEUE_AW:0]    count;

  assign full    = (count == (bst_pkg::QUEUE_AW+1)'(bst_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (bst_pkg::QUEUE_AW+1)'(wr && !full)
                     - (bst_pkg::QUEUE_AW+1)'(rd && !empty);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && full))
    else $error("write to full queue");

endmodule
`default_nettype wire

// File: rtl/bst_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bst_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bst_pkg::entry_t q_data,
  input  wire logic            q_empty,
  output logic                 q_rd,
  input  wire logic            pop,
  output logic                 empty,
  output logic [3:0]           token_kind,
  output logic [15:0]          token_start,
  output logic [15:0]          token_length,
  output logic [1:0]           error_cause,
  output logic                 last_of_run
);

  bst_pkg::entry_t stage;
  logic            valid;
  logic            idx;
  bst_pkg::tok_t   cur;
  logic            take;

  assign cur          = idx ? stage.second : stage.first;
  assign token_kind   = cur.kind;
  assign token_start  = cur.start;
  assign token_length = cur.length;
  assign error_cause  = cur.cause;
  assign last_of_run  = !stage.two || idx;
  assign empty        = !valid;

  assign take = pop && valid;
  assign q_rd = (!valid || (take && last_of_run)) && !q_empty;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      stage <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 1'b0;
    end else if (q_rd) begin
      valid <= 1'b1;
      idx   <= 1'b0;
    end else if (take) begin
      if (last_of_run) begin
        valid <= 1'b0;
        idx   <= 1'b0;
      end else begin
        idx <= 1'b1;
      end
    end
  end

  a_second_only_for_pairs: assert property (@(posedge clk) disable iff (rst)
    (valid && idx) |-> stage.two)
    else $error("second slot shown for single-token transaction");

endmodule
`default_nettype wire

// File: rtl/byte_stream_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none
// A token reaches the result ports through a queue slot and then the registered
// output stage. Throughput: one byte per cycle while full is low; a byte that ends
// a token and is itself a one-byte token yields two tokens, which leave one per pop.
// A 4-entry queue sits between the scanner and the output stage.
// Reset: synchronous rst clears scan state, position, queue and output stage.
module byte_stream_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  text_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       token_kind,
  output logic [15:0]      token_start,
  output logic [15:0]      token_length,
  output logic [1:0]       error_cause,
  output logic             last_of_run
);

  logic            q_push;
  bst_pkg::entry_t q_wdata;
  bst_pkg::entry_t q_rdata;
  logic            q_rd;
  logic            q_empty;

  bst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .text_byte (text_byte),
    .q_push    (q_push),
    .q_entry   (q_wdata)
  );

  bst_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wdata),
    .rd      (q_rd),
    .rd_data (q_rdata),
    .full    (full),
    .empty   (q_empty)
  );

  bst_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_rdata),
    .q_empty      (q_empty),
    .q_rd         (q_rd),
    .pop          (pop),
    .empty        (empty),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .error_cause  (error_cause),
    .last_of_run  (last_of_run)
  );

endmodule
`default_nettype wire

// File: tb/byte_stream_tokenizer_tb.sv
`timescale 1ns / 1ps
module byte_stream_tokenizer_tb;

  localparam logic [2:0] SCAN_IDLE   = 3'd0;
  localparam logic [2:0] SCAN_CR     = 3'd1;
  localparam logic [2:0] SCAN_COLON  = 3'd2;
  localparam logic [2:0] SCAN_WORD   = 3'd3;
  localparam logic [2:0] SCAN_NUMBER = 3'd4;
  localparam logic [2:0] SCAN_HALTED = 3'd5;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [1:0]  cause;
    logic        last;
  } token_rec_t;

  class token_scoreboard;
    logic [2:0]                    mode;
    logic [bst_pkg::POS_WIDTH-1:0] pos;
    logic [bst_pkg::POS_WIDTH-1:0] lex_begin;
    int                            kw_matched;
    bit                            kw_alive;
    string                         keyword = "while";
    token_rec_t                    byte_tokens[$];
    token_rec_t                    expected_tokens[$];
    int                            errors;
    int                            checked;
    bit                            kind_seen[16];

    function new();
      mode = SCAN_IDLE;
      pos = '0;
      lex_begin = '0;
      kw_matched = 0;
      kw_alive = 1;
      errors = 0;
      checked = 0;
    endfunction

    function bit digit_byte(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit word_start_byte(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == bst_pkg::CH_UNDER;
    endfunction

    function void emit(logic [3:0] kind, logic [bst_pkg::POS_WIDTH-1:0] at,
                       logic [bst_pkg::POS_WIDTH-1:0] len, logic [1:0] cause);
      token_rec_t t;
      t.kind = kind;
      t.start = 16'(at);
      t.length = 16'(len);
      t.cause = cause;
      t.last = 1'b0;
      byte_tokens.push_back(t);
    endfunction

    function void kw_track(logic [7:0] c);
      if (kw_alive && kw_matched < keyword.len() && c == keyword[kw_matched]) begin
        kw_matched++;
      end else begin
        kw_alive = 0;
      end
    endfunction

    // returns 1 when end of text restarted the position count
    function bit idle_scan(logic [7:0] c, logic [bst_pkg::POS_WIDTH-1:0] p);
      bit restart;
      restart = 0;
      unique case (c)
        bst_pkg::CH_SPACE, bst_pkg::CH_TAB: ;
        bst_pkg::CH_NUL: begin
          emit(bst_pkg::KIND_EOF, p, '0, bst_pkg::CAUSE_NONE);
          mode = SCAN_IDLE;
          pos = '0;
          restart = 1;
        end
        bst_pkg::CH_CR: begin
          lex_begin = p;
          mode = SCAN_CR;
        end
        bst_pkg::CH_LF:     emit(bst_pkg::KIND_NL, p, '0, bst_pkg::CAUSE_NONE);
        bst_pkg::CH_LPAREN: emit(bst_pkg::KIND_LPAREN, p, '0, bst_pkg::CAUSE_NONE);
        bst_pkg::CH_RPAREN: emit(bst_pkg::KIND_RPAREN, p, '0, bst_pkg::CAUSE_NONE);
        bst_pkg::CH_LBRACE: emit(bst_pkg::KIND_LBRACE, p, '0, bst_pkg::CAUSE_NONE);
        bst_pkg::CH_RBRACE: emit(bst_pkg::KIND_RBRACE, p, '0, bst_pkg::CAUSE_NONE);
        bst_pkg::CH_LESS:   emit(bst_pkg::KIND_LESS, p, '0, bst_pkg::CAUSE_NONE);
        bst_pkg::CH_PLUS:   emit(bst_pkg::KIND_PLUS, p, '0, bst_pkg::CAUSE_NONE);
        bst_pkg::CH_MINUS:  emit(bst_pkg::KIND_MINUS, p, '0, bst_pkg::CAUSE_NONE);
        bst_pkg::CH_COLON: begin
          lex_begin = p;
          mode = SCAN_COLON;
        end
        default: begin
          if (word_start_byte(c)) begin
            lex_begin = p;
            mode = SCAN_WORD;
            kw_matched = 0;
            kw_alive = 1;
            kw_track(c);
          end else if (digit_byte(c)) begin
            lex_begin = p;
            mode = SCAN_NUMBER;
          end else begin
            emit(bst_pkg::KIND_ERROR, p, '0, bst_pkg::CAUSE_BAD_CHAR);
            mode = SCAN_HALTED;
          end
        end
      endcase
      return restart;
    endfunction

    function void note_byte(logic [7:0] c);
      logic [bst_pkg::POS_WIDTH-1:0] p;
      bit                            restart;
      token_rec_t                    t;
      if (mode == SCAN_HALTED) return;
      p = pos;
      restart = 0;
      unique case (mode)
        SCAN_CR: begin
          mode = SCAN_IDLE;
          emit(bst_pkg::KIND_NL, lex_begin, '0, bst_pkg::CAUSE_NONE);
          if (c != bst_pkg::CH_LF) restart = idle_scan(c, p);
        end
        SCAN_COLON: begin
          if (c == bst_pkg::CH_EQUAL) begin
            emit(bst_pkg::KIND_ASSIGN, lex_begin, '0, bst_pkg::CAUSE_NONE);
            mode = SCAN_IDLE;
          end else begin
            emit(bst_pkg::KIND_ERROR, p, '0, bst_pkg::CAUSE_NO_EQUAL);
            mode = SCAN_HALTED;
          end
        end
        SCAN_WORD: begin
          if (word_start_byte(c) || digit_byte(c)) begin
            kw_track(c);
          end else begin
            emit((kw_alive && kw_matched == keyword.len()) ?
                 bst_pkg::KIND_WHILE : bst_pkg::KIND_IDENT,
                 lex_begin, p - lex_begin, bst_pkg::CAUSE_NONE);
            mode = SCAN_IDLE;
            restart = idle_scan(c, p);
          end
        end
        SCAN_NUMBER: begin
          if (!digit_byte(c)) begin
            emit(bst_pkg::KIND_INT, lex_begin, p - lex_begin, bst_pkg::CAUSE_NONE);
            mode = SCAN_IDLE;
            restart = idle_scan(c, p);
          end
        end
        default: begin
          mode = SCAN_IDLE;
          restart = idle_scan(c, p);
        end
      endcase
      if (!restart && pos != '1) pos = pos + 1'b1;
      if (byte_tokens.size() > 0) begin
        t = byte_tokens.pop_back();
        t.last = 1'b1;
        byte_tokens.push_back(t);
      end
      foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
      byte_tokens.delete();
    endfunction

    function void complain(string what, token_rec_t want, token_rec_t got);
      errors++;
      if (errors <= 10)
        $display("[%0t] %s: expected kind %0d start %0d len %0d cause %0d last %0b,",
                 $time, what, want.kind, want.start, want.length, want.cause, want.last,
                 " got kind %0d start %0d len %0d cause %0d last %0b",
                 got.kind, got.start, got.length, got.cause, got.last);
    endfunction

    function void check_token(token_rec_t got);
      token_rec_t want;
      if (expected_tokens.size() == 0) begin
        complain("token with none pending", '0, got);
        return;
      end
      want = expected_tokens.pop_front();
      checked++;
      if (got.kind !== want.kind || got.start !== want.start ||
          got.length !== want.length || got.cause !== want.cause ||
          got.last !== want.last) begin
        complain("token mismatch", want, got);
      end else begin
        kind_seen[want.kind] = 1;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  text_byte = 8'h00;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [1:0]  error_cause;
  logic        last_of_run;

  token_scoreboard sb = new();

  int burst_left = 0;
  bit no_gaps = 0;
  int work_bytes = 0;
  int bytes_in = 0;
  int held_cycles = 0;
  logic hold_req = 1'b0;

  int pop_every = 1;
  int phase_left = 0;
  int pop_tick = 0;
  int hold_left = 0;
  bit hold_taken = 0;

  byte_stream_tokenizer dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .text_byte(text_byte),
    .empty(empty),
    .pop(pop),
    .token_kind(token_kind),
    .token_start(token_start),
    .token_length(token_length),
    .error_cause(error_cause),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200_000;
    $display("timeout with %0d tokens still pending", sb.expected_tokens.size());
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin : monitor
    token_rec_t got;
    if (!rst) begin
      if (push && !full) begin
        sb.note_byte(text_byte);
        bytes_in++;
      end
      if (push && full) held_cycles++;
      if (pop && !empty) begin
        got.kind = token_kind;
        got.start = token_start;
        got.length = token_length;
        got.cause = error_cause;
        got.last = last_of_run;
        sb.check_token(got);
      end
    end
  end

  // receiver: pops with a random spacing that changes per stretch; one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1;
      hold_left = 400;
      pop <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        pop_every = $urandom_range(1, 4);
        phase_left = $urandom_range(16, 80);
      end
      phase_left--;
      pop_tick++;
      pop <= (pop_tick % pop_every) == 0;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    text_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    work_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // stop offering and wait until every expected token has been popped
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (sb.expected_tokens.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] word_char(input bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    if (r == 52) return bst_pkg::CH_UNDER;
    return 8'("0" + r - 53);
  endfunction

  task automatic send_lexeme();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      case ($urandom_range(0, 7))
        0: send_text("while");
        1: send_text("whil");
        2: send_text("whilee");
        3: send_text("While");
        default: begin
          n = $urandom_range(1, 8);
          send_byte(word_char(1));
          repeat (n - 1) send_byte(word_char(0));
        end
      endcase
    end else if (pick < 45) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'("0" + $urandom_range(0, 9)));
    end else if (pick < 70) begin
      case ($urandom_range(0, 6))
        0: send_byte(bst_pkg::CH_LPAREN);
        1: send_byte(bst_pkg::CH_RPAREN);
        2: send_byte(bst_pkg::CH_LBRACE);
        3: send_byte(bst_pkg::CH_RBRACE);
        4: send_byte(bst_pkg::CH_LESS);
        5: send_byte(bst_pkg::CH_PLUS);
        default: send_byte(bst_pkg::CH_MINUS);
      endcase
    end else if (pick < 76) begin
      send_text(":=");
    end else if (pick < 84) begin
      case ($urandom_range(0, 2))
        0: send_byte(bst_pkg::CH_LF);
        1: send_byte(bst_pkg::CH_CR);
        default: send_text("\r\n");
      endcase
    end else if (pick < 97) begin
      repeat ($urandom_range(1, 3))
        send_byte($urandom_range(0, 1) ? bst_pkg::CH_SPACE : bst_pkg::CH_TAB);
    end else begin
      send_byte(bst_pkg::CH_NUL);
    end
  endtask

  initial begin
    string      bad_chars;
    logic [7:0] c;
    int         stop_at;
    int         kinds;
    bad_chars = "@#$%!?;,.=*/&|^~[]";
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // keyword vs. near misses, CR LF merge, CR before a token, assign, eof ending an ident
    send_text("while(whil:=9)\r\n{_}\t-<+\r(Z");
    send_byte(bst_pkg::CH_NUL);
    drain();

    stop_at = work_bytes + 1050;
    while (work_bytes < stop_at) begin
      send_lexeme();
      if (!hold_req && work_bytes > stop_at - 600) begin
        drain();
        hold_req <= 1'b1;
        no_gaps = 1;
        repeat (40) send_text("()");
        no_gaps = 0;
      end
    end
    drain();

    // restart from position 0, then a short mixed line
    send_byte(bst_pkg::CH_NUL);
    send_text("whilex1 (7+x:=\r");
    send_byte(bst_pkg::CH_NUL);
    send_text("-12 ");
    drain();

    // one error, then lockout: later bytes give nothing
    send_text("ab");
    if ($urandom_range(0, 1)) begin
      send_byte(bst_pkg::CH_COLON);
      do c = 8'($urandom_range(0, 255)); while (c == bst_pkg::CH_EQUAL);
      if ($urandom_range(0, 3) == 0) c = bst_pkg::CH_NUL;
      send_byte(c);
    end else begin
      c = $urandom_range(0, 1) ? 8'($urandom_range(128, 255))
                               : bad_chars[$urandom_range(0, bad_chars.len() - 1)];
      send_byte(c);
    end
    repeat (40) send_byte(8'($urandom_range(0, 255)));
    send_byte(8'hFF);
    send_byte(bst_pkg::CH_NUL);
    send_text("x(");

    push <= 1'b0;
    do @(posedge clk); while (sb.expected_tokens.size() != 0);
    repeat (20) @(posedge clk);

    kinds = 0;
    foreach (sb.kind_seen[i]) kinds += sb.kind_seen[i];
    $display("%0d bytes in, %0d tokens checked, %0d of 14 token kinds seen",
             bytes_in, sb.checked, kinds);
    $display("input held off for %0d cycles; keyword near misses and error lockout exercised",
             held_cycles);
    if (sb.errors > 0) $display("%0d mismatches in total", sb.errors);
    if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bst_pkg.sv
rtl/bst_front.sv
rtl/bst_fifo.sv
rtl/bst_back.sv
rtl/byte_stream_tokenizer.sv
tb/byte_stream_tokenizer_tb.sv
